/* hdl/spg_pkg.sv */
`timescale 1ns / 1ps

package spg_pkg;

    // Half period divider geometry
    localparam int DIV_W = 29;   // dividend and quotient width
    localparam int DSR_W = 36;   // divisor width
    localparam int CNT_W = 5;    // iteration counter, holds DIV_W

    localparam logic [15:0]      SPR_RESET = 16'd200;
    // Step count is prod / 5760: drop 7 bits (5760 = 128 * 45), then multiply by
    // ceil(2^38 / 45) = 2^32 + DEG_RECIP_LO and keep bits 38 and up
    localparam logic [30:0]      DEG_RECIP_LO = 31'd1813430637;
    localparam logic [DIV_W-1:0] HP_NUM    = 29'd480000000;   // 60e6 * 16 / 2
    localparam logic [28:0]      HP_SAT    = 29'd480000000;
    localparam logic [28:0]      HP_MIN    = 29'd2;
    localparam logic [28:0]      ELAPSED_MAX = 29'h1FFFFFFF;

    typedef struct packed {
        logic immediate;   // handle the request in the accept cycle
        logic capture;     // store start fields for the long path
        logic mul;         // register both products
        logic recip;       // multiply the scaled product by the low part of the reciprocal
        logic take_steps;  // store step count
        logic div_hp;      // launch half period division
        logic commit;      // apply the new move and load the result
    } t_dp_cmd;

    typedef struct packed {
        logic needs_compute;
        logic div_done;
    } t_dp_sts;

endpackage

/* hdl/spg_div.sv */
`timescale 1ns / 1ps

module spg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [spg_pkg::DIV_W-1:0] i_dividend,
    input  logic [spg_pkg::DSR_W-1:0] i_divisor,
    output logic [spg_pkg::DIV_W-1:0] o_quotient,
    output logic                      o_done
);
    import spg_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W:0]   r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DSR_W-1:0] r_divisor;

    logic [DSR_W:0]   shifted;
    logic [DSR_W+1:0] diff;

    // Restoring division, one quotient bit per cycle, MSB first
    assign shifted = {r_rem[DSR_W-1:0], r_quo[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            if (!diff[DSR_W+1]) begin
                r_rem <= diff[DSR_W:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

/* hdl/spg_dp.sv */
`timescale 1ns / 1ps

module spg_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spg_pkg::t_dp_cmd i_cmd,
    output spg_pkg::t_dp_sts o_sts,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_wdata,
    input  logic             i_kind,
    input  logic [1:0]       i_motor_select,
    input  logic [23:0]      i_angle_deg_q4,
    input  logic             i_turn_dir,
    input  logic [19:0]      i_speed_rpm_q4,
    input  logic [1:0]       i_fault_n,
    output logic [1:0]       o_step_level,
    output logic             o_dir_level,
    output logic [1:0]       o_driver_enable,
    output logic [2:0]       o_status,
    output logic [26:0]      o_steps_left
);
    import spg_pkg::*;

    localparam logic KIND_START = 1'b0;

    localparam logic [1:0] SEL_ONE  = 2'd0;
    localparam logic [1:0] SEL_TWO  = 2'd1;
    localparam logic [1:0] SEL_NONE = 2'd3;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MOVING   = 3'd1;
    localparam logic [2:0] ST_FINISHED = 3'd2;
    localparam logic [2:0] ST_FAULT    = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;

    // Move state
    logic [15:0] r_spr;
    logic        r_moving, n_moving;
    logic [1:0]  r_sel, n_sel;
    logic        r_dir, n_dir;
    logic        r_pulse, n_pulse;
    logic [26:0] r_rem, n_rem;
    logic [28:0] r_hp, n_hp;
    logic [28:0] r_elapsed, n_elapsed;
    logic        r_first, n_first;
    logic [2:0]  n_status;

    // Start request held through the long path
    logic [1:0]  r_c_sel;
    logic        r_c_dir;
    logic [23:0] r_c_mag;
    logic [19:0] r_c_rpm;
    logic [38:0] r_prod;
    logic [35:0] r_den;
    logic [62:0] r_recip;
    logic [26:0] r_steps;

    // Result register
    logic [1:0]  r_o_step;
    logic        r_o_dir;
    logic [1:0]  r_o_en;
    logic [2:0]  r_o_status;
    logic [26:0] r_o_rem;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DSR_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quo;
    logic             div_done;

    logic [23:0] mag;
    logic [1:0]  faults;
    logic [28:0] el_inc;
    logic        toggle;
    logic [26:0] rem_dec;
    logic [28:0] hp_q;
    logic [64:0] steps_sum;

    assign mag = i_angle_deg_q4[23] ? (24'd0 - i_angle_deg_q4) : i_angle_deg_q4;

    always_comb begin
        o_sts.needs_compute = (i_kind == KIND_START) && !r_moving
                              && (i_motor_select != SEL_NONE);
        o_sts.div_done      = div_done;
    end

    assign div_start    = i_cmd.div_hp;
    assign div_dividend = HP_NUM;
    assign div_divisor  = r_den;

    // Top bit of the reciprocal is 2^32: add the scaled product shifted up
    assign steps_sum = {1'b0, r_prod[38:7], 32'd0} + {2'b00, r_recip};

    spg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    // Clamp the half period; a zero product saturates
    always_comb begin
        if (r_den == '0) begin
            hp_q = HP_SAT;
        end else if (div_quo[28:0] < HP_MIN) begin
            hp_q = HP_MIN;
        end else begin
            hp_q = div_quo[28:0];
        end
    end

    always_comb begin
        faults    = ~i_fault_n & r_sel;
        el_inc    = (r_elapsed < ELAPSED_MAX) ? (r_elapsed + 29'd1) : r_elapsed;
        toggle    = r_first || (el_inc >= r_hp);
        rem_dec   = (r_rem != '0) ? (r_rem - 27'd1) : r_rem;

        n_moving  = r_moving;
        n_sel     = r_sel;
        n_dir     = r_dir;
        n_pulse   = r_pulse;
        n_rem     = r_rem;
        n_hp      = r_hp;
        n_elapsed = r_elapsed;
        n_first   = r_first;
        n_status  = ST_IDLE;

        if (i_cmd.commit) begin
            n_dir     = r_c_dir;
            n_sel     = (r_c_sel == SEL_ONE) ? 2'b01 :
                        (r_c_sel == SEL_TWO) ? 2'b10 : 2'b11;
            n_rem     = r_steps;
            n_hp      = hp_q;
            n_elapsed = '0;
            n_pulse   = 1'b0;
            n_first   = 1'b1;
            n_moving  = (r_steps != '0);
            n_status  = (r_steps != '0) ? ST_MOVING : ST_FINISHED;
        end else if (i_kind == KIND_START) begin
            if (r_moving) begin
                n_status = ST_REJECTED;
            end else begin
                // No motor selected: latch direction, clear selection and step count
                n_dir    = i_turn_dir;
                n_sel    = '0;
                n_rem    = '0;
                n_status = ST_IDLE;
            end
        end else if (r_moving) begin
            if (faults != '0) begin
                n_moving = 1'b0;
                n_status = ST_FAULT;
            end else if (!toggle) begin
                n_elapsed = el_inc;
                n_status  = ST_MOVING;
            end else begin
                n_first   = 1'b0;
                n_elapsed = '0;
                if (!r_pulse) begin
                    n_pulse  = 1'b1;
                    n_status = ST_MOVING;
                end else begin
                    // Falling edge completes a step
                    n_pulse = 1'b0;
                    n_rem   = rem_dec;
                    if (rem_dec == '0) begin
                        n_moving = 1'b0;
                        n_status = ST_FINISHED;
                    end else begin
                        n_status = ST_MOVING;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr     <= SPR_RESET;
            r_moving  <= 1'b0;
            r_sel     <= '0;
            r_dir     <= 1'b0;
            r_pulse   <= 1'b0;
            r_rem     <= '0;
            r_hp      <= HP_MIN;
            r_elapsed <= '0;
            r_first   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_spr <= i_cfg_wdata;
            end
            if (i_cmd.immediate || i_cmd.commit) begin
                r_moving  <= n_moving;
                r_sel     <= n_sel;
                r_dir     <= n_dir;
                r_pulse   <= n_pulse;
                r_rem     <= n_rem;
                r_hp      <= n_hp;
                r_elapsed <= n_elapsed;
                r_first   <= n_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_c_sel <= i_motor_select;
            r_c_dir <= i_turn_dir;
            r_c_mag <= mag;
            r_c_rpm <= i_speed_rpm_q4;
        end
        if (i_cmd.mul) begin
            r_prod <= r_c_mag * r_spr;
            r_den  <= r_c_rpm * r_spr;
        end
        if (i_cmd.recip) begin
            r_recip <= r_prod[38:7] * DEG_RECIP_LO;
        end
        if (i_cmd.take_steps) begin
            r_steps <= steps_sum[64:38];
        end
        if (i_cmd.immediate || i_cmd.commit) begin
            r_o_step   <= n_pulse ? n_sel : 2'b00;
            r_o_dir    <= n_dir;
            r_o_en     <= n_moving ? n_sel : 2'b00;
            r_o_status <= n_status;
            r_o_rem    <= n_rem;
        end
    end

    assign o_step_level    = r_o_step;
    assign o_dir_level     = r_o_dir;
    assign o_driver_enable = r_o_en;
    assign o_status        = r_o_status;
    assign o_steps_left    = r_o_rem;

endmodule

/* hdl/spg_ctrl.sv */
`timescale 1ns / 1ps

module spg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  spg_pkg::t_dp_sts i_sts,
    output spg_pkg::t_dp_cmd o_cmd
);
    import spg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RECIP,
        S_STEPS,
        S_DH_GO,
        S_DH_WAIT,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.immediate  = accept && !i_sts.needs_compute;
        o_cmd.capture    = accept && i_sts.needs_compute;
        o_cmd.mul        = (r_state == S_MUL);
        o_cmd.recip      = (r_state == S_RECIP);
        o_cmd.take_steps = (r_state == S_STEPS);
        o_cmd.div_hp     = (r_state == S_DH_GO);
        o_cmd.commit     = (r_state == S_COMMIT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.immediate || o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:   r_state <= S_RECIP;
                S_RECIP: r_state <= S_STEPS;
                S_STEPS: r_state <= S_DH_GO;
                S_DH_GO: r_state <= S_DH_WAIT;
                S_DH_WAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    // hold until the result register is free
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/stepper_pulse_generator_unit.sv */
`timescale 1ns / 1ps

// Channel   Handshake                      Payload
// input     i_in_valid / o_in_ready        i_kind, i_motor_select, i_angle_deg_q4,
//                                          i_turn_dir, i_speed_rpm_q4, i_fault_n
// output    o_out_valid / i_out_ready      o_step_level, o_dir_level,
//                                          o_driver_enable, o_status, o_steps_left
// config    i_cfg_we                       i_cfg_wdata (steps per revolution)
//
// A tick, a rejected start or a start with no motor has its result registered at
// the accept edge. A start with a motor selected registers its result at the commit
// and takes the next request only after the commit, through these steps: one
// multiply, a reciprocal multiply, a step count cycle, a launch and 29 iterations
// of the restoring divider for the half period, a finish cycle, then the commit.
// Synchronous active-low reset; no clearing pass. A stalled output holds the
// result and blocks only the next request, which is taken as the result drains.

module stepper_pulse_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [1:0]  i_motor_select,
    input  logic [23:0] i_angle_deg_q4,
    input  logic        i_turn_dir,
    input  logic [19:0] i_speed_rpm_q4,
    input  logic [1:0]  i_fault_n,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_step_level,
    output logic        o_dir_level,
    output logic [1:0]  o_driver_enable,
    output logic [2:0]  o_status,
    output logic [26:0] o_steps_left
);
    import spg_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    spg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    spg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_kind          (i_kind),
        .i_motor_select  (i_motor_select),
        .i_angle_deg_q4  (i_angle_deg_q4),
        .i_turn_dir      (i_turn_dir),
        .i_speed_rpm_q4  (i_speed_rpm_q4),
        .i_fault_n       (i_fault_n),
        .o_step_level    (o_step_level),
        .o_dir_level     (o_dir_level),
        .o_driver_enable (o_driver_enable),
        .o_status        (o_status),
        .o_steps_left    (o_steps_left)
    );

endmodule

/* tb/sv/stepper_pulse_generator_unit_tb.sv */
`timescale 1ns / 1ps

module stepper_pulse_generator_unit_tb;

    localparam logic       KIND_START = 1'b0;
    localparam logic       KIND_TICK  = 1'b1;

    localparam logic [1:0] SEL_M1   = 2'd0;
    localparam logic [1:0] SEL_M2   = 2'd1;
    localparam logic [1:0] SEL_BOTH = 2'd2;
    localparam logic [1:0] SEL_NONE = 2'd3;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MOVING = 3'd1;
    localparam logic [2:0] ST_DONE   = 3'd2;
    localparam logic [2:0] ST_FAULT  = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;

    localparam longint unsigned HALF_NUM    = 64'd480000000;
    localparam logic [28:0]     HALF_SAT    = 29'd480000000;
    localparam logic [28:0]     ELAPSED_TOP = 29'h1FFFFFFF;
    localparam longint unsigned DEG_DIV     = 64'd5760;

    localparam int PHASES       = 6;
    localparam int PHASE_LEN    = 110;
    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic        kind;
        logic [1:0]  sel;
        logic [23:0] angle;
        logic        dir;
        logic [19:0] rpm;
        logic [1:0]  fault_n;
    } t_motor_req;

    typedef struct packed {
        logic [1:0]  step;
        logic        dir;
        logic [1:0]  en;
        logic [2:0]  status;
        logic [26:0] left;
    } t_pulse_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_kind = 1'b0;
    logic [1:0]  i_motor_select = '0;
    logic [23:0] i_angle_deg_q4 = '0;
    logic        i_turn_dir = 1'b0;
    logic [19:0] i_speed_rpm_q4 = '0;
    logic [1:0]  i_fault_n = 2'b11;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic [1:0]  o_step_level;
    logic        o_dir_level;
    logic [1:0]  o_driver_enable;
    logic [2:0]  o_status;
    logic [26:0] o_steps_left;

    stepper_pulse_generator_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_motor_select (i_motor_select),
        .i_angle_deg_q4 (i_angle_deg_q4),
        .i_turn_dir     (i_turn_dir),
        .i_speed_rpm_q4 (i_speed_rpm_q4),
        .i_fault_n      (i_fault_n),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_step_level   (o_step_level),
        .o_dir_level    (o_dir_level),
        .o_driver_enable(o_driver_enable),
        .o_status       (o_status),
        .o_steps_left   (o_steps_left)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Motion state tracked alongside the block
    logic [15:0] cfg_spr = 16'd200;
    logic        mv_moving = 1'b0;
    logic [1:0]  mv_sel = '0;
    logic        mv_dir = 1'b0;
    logic        mv_level = 1'b0;
    logic [26:0] mv_left = '0;
    logic [28:0] mv_half = 29'd2;
    logic [28:0] mv_elapsed = '0;
    logic        mv_first = 1'b0;

    t_motor_req    pending_reqs[$];
    t_pulse_result expected_results[$];
    t_motor_req    cur_req = '0;

    logic        in_busy = 1'b0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    logic        calm = 1'b0;
    int unsigned in_gap = 0;
    int unsigned out_stall = 0;
    int unsigned idle_cycles = 0;
    int unsigned req_count = 0;
    int unsigned res_count = 0;
    int unsigned mismatches = 0;
    int unsigned n_done = 0;
    int unsigned n_fault = 0;
    int unsigned n_reject = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH result %0d: %s", res_count, msg);
        mismatches++;
    endtask

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic advance_motion(input t_motor_req r, output t_pulse_result res);
        logic [2:0]      st;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned quot;
        logic            flip;
        st = ST_IDLE;
        if (r.kind == KIND_START) begin
            if (mv_moving) begin
                st = ST_REJECT;
            end else begin
                mv_dir = r.dir;
                if (r.sel == SEL_NONE) begin
                    mv_sel = 2'b00;
                    mv_left = '0;
                end else begin
                    mag = r.angle[23] ? (64'h1000000 - 64'(r.angle)) : 64'(r.angle);
                    quot = (mag * 64'(cfg_spr)) / DEG_DIV;
                    den = 64'(cfg_spr) * 64'(r.rpm);
                    if (den == 0) begin
                        mv_half = HALF_SAT;
                    end else if (HALF_NUM / den < 2) begin
                        mv_half = 29'd2;
                    end else begin
                        mv_half = 29'(HALF_NUM / den);
                    end
                    case (r.sel)
                        SEL_M1:  mv_sel = 2'b01;
                        SEL_M2:  mv_sel = 2'b10;
                        default: mv_sel = 2'b11;
                    endcase
                    mv_left = quot[26:0];
                    mv_elapsed = '0;
                    mv_level = 1'b0;
                    mv_first = 1'b1;
                    mv_moving = (mv_left != 0);
                    st = mv_moving ? ST_MOVING : ST_DONE;
                end
            end
        end else if (mv_moving) begin
            if ((~r.fault_n & mv_sel) != 2'b00) begin
                mv_moving = 1'b0;
                st = ST_FAULT;
            end else begin
                st = ST_MOVING;
                if (mv_first) begin
                    flip = 1'b1;
                end else begin
                    if (mv_elapsed < ELAPSED_TOP) mv_elapsed++;
                    flip = (mv_elapsed >= mv_half);
                end
                if (flip) begin
                    mv_first = 1'b0;
                    mv_elapsed = '0;
                    if (!mv_level) begin
                        mv_level = 1'b1;
                    end else begin
                        // falling edge completes a step
                        mv_level = 1'b0;
                        if (mv_left != 0) mv_left--;
                        if (mv_left == 0) begin
                            mv_moving = 1'b0;
                            st = ST_DONE;
                        end
                    end
                end
            end
        end
        res.step = mv_level ? mv_sel : 2'b00;
        res.dir = mv_dir;
        res.en = mv_moving ? mv_sel : 2'b00;
        res.status = st;
        res.left = mv_left;
    endtask

    task automatic push_req(input logic kind, input logic [1:0] sel, input logic [23:0] angle,
                            input logic dir, input logic [19:0] rpm, input logic [1:0] fault_n);
        t_motor_req r;
        r.kind = kind;
        r.sel = sel;
        r.angle = angle;
        r.dir = dir;
        r.rpm = rpm;
        r.fault_n = fault_n;
        pending_reqs.push_back(r);
    endtask

    // One start with a short, reachable step count and half period, then enough ticks
    // to finish it, sometimes cut short or ended by a fault.
    task automatic queue_move(input logic [15:0] spr);
        longint unsigned hp;
        longint unsigned steps;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned est;
        logic [19:0]     rpm;
        logic [1:0]      sel;
        int unsigned     ticks;
        sel = ($urandom_range(0, 15) == 0) ? SEL_NONE : 2'($urandom_range(0, 2));
        hp = $urandom_range(2, 6);
        den = (spr == 0) ? 64'd1 : 64'(spr) * hp;
        rpm = (HALF_NUM / den > 64'hFFFFF) ? 20'hFFFFF : 20'(HALF_NUM / den);
        den = 64'(spr) * 64'(rpm);
        if (den == 0) hp = HALF_SAT;
        else hp = (HALF_NUM / den < 2) ? 2 : HALF_NUM / den;
        steps = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) mag = 0;
        else if (spr == 0) mag = $urandom_range(0, 24'h7FFFFF);
        else mag = (steps * DEG_DIV + 64'(spr) - 1) / 64'(spr);
        if (mag > 64'h7FFFFF) mag = 64'h7FFFFF;
        steps = (mag * 64'(spr)) / DEG_DIV;
        push_req(KIND_START, sel, $urandom_range(0, 1) ? 24'(-mag) : 24'(mag),
                 1'($urandom), rpm, 2'($urandom));
        est = (steps == 0 || sel == SEL_NONE) ? 0 : 1 + (2 * steps - 1) * hp;
        ticks = (est <= 120) ? int'(est) + $urandom_range(0, 3) : $urandom_range(5, 40);
        if ($urandom_range(0, 4) == 0) ticks = $urandom_range(0, ticks);
        repeat (ticks) begin
            push_req(KIND_TICK, 2'($urandom), 24'($urandom), 1'($urandom), 20'($urandom),
                     ($urandom_range(0, 39) == 0) ? 2'($urandom) : 2'b11);
        end
        if ($urandom_range(0, 1)) begin
            push_req(KIND_TICK, 2'($urandom), 24'($urandom), 1'($urandom), 20'($urandom),
                     2'b00);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_busy || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Drive requests and output ready at the falling edge
    always @(negedge i_clk) begin
        if (in_taken) begin
            in_taken = 1'b0;
            in_busy = 1'b0;
            in_gap = draw_wait();
        end
        if (!in_busy) begin
            if (in_gap != 0) begin
                in_gap--;
            end else if (pending_reqs.size() != 0) begin
                cur_req = pending_reqs.pop_front();
                in_busy = 1'b1;
            end
        end
        i_in_valid <= in_busy;
        i_kind <= cur_req.kind;
        i_motor_select <= cur_req.sel;
        i_angle_deg_q4 <= cur_req.angle;
        i_turn_dir <= cur_req.dir;
        i_speed_rpm_q4 <= cur_req.rpm;
        i_fault_n <= cur_req.fault_n;

        if (out_taken) begin
            out_taken = 1'b0;
            out_stall = draw_wait();
        end
        if (out_stall != 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check results, record accepted requests, watch for a hang
    always @(posedge i_clk) begin
        t_pulse_result want;
        t_pulse_result pred;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                out_taken = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request waiting");
                end else begin
                    want = expected_results.pop_front();
                    if (o_step_level !== want.step)
                        report_mismatch($sformatf("step_level %0h, expected %0h",
                                                  o_step_level, want.step));
                    if (o_dir_level !== want.dir)
                        report_mismatch($sformatf("dir_level %0h, expected %0h",
                                                  o_dir_level, want.dir));
                    if (o_driver_enable !== want.en)
                        report_mismatch($sformatf("driver_enable %0h, expected %0h",
                                                  o_driver_enable, want.en));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_steps_left !== want.left)
                        report_mismatch($sformatf("steps_left %0d, expected %0d",
                                                  o_steps_left, want.left));
                    case (want.status)
                        ST_DONE:   n_done++;
                        ST_FAULT:  n_fault++;
                        ST_REJECT: n_reject++;
                        default: ;
                    endcase
                end
                res_count++;
            end
            if (i_in_valid && o_in_ready) begin
                advance_motion(cur_req, pred);
                expected_results.push_back(pred);
                in_taken = 1'b1;
                req_count++;
                // switch between idling and back-to-back stretches
                if (req_count % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timed out: no handshake for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] spr_plan [PHASES];
        spr_plan[0] = 16'd200;
        spr_plan[1] = 16'd1;
        spr_plan[2] = 16'hFFFF;
        spr_plan[3] = 16'd0;
        spr_plan[4] = 16'($urandom_range(2, 65535));
        spr_plan[5] = 16'd48;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset step count
        push_req(KIND_TICK, SEL_NONE, 24'h000000, 1'b0, 20'h00000, 2'b00);
        push_req(KIND_START, SEL_NONE, 24'h7FFFFF, 1'b1, 20'hFFFFF, 2'b11);
        push_req(KIND_START, SEL_M1, 24'h000000, 1'b0, 20'd1000, 2'b11);
        // largest magnitude with rpm of zero: huge move, saturated half period
        push_req(KIND_START, SEL_BOTH, 24'h800000, 1'b1, 20'h00000, 2'b11);
        push_req(KIND_START, SEL_M2, 24'd100, 1'b0, 20'd5000, 2'b11);
        push_req(KIND_TICK, SEL_M1, 24'hFFFFFF, 1'b1, 20'hFFFFF, 2'b11);
        // motor two faults while high: level must stay visible
        push_req(KIND_TICK, SEL_M1, 24'h000000, 1'b0, 20'h00000, 2'b01);
        push_req(KIND_START, SEL_M2, 24'd29, 1'b0, 20'hFFFFF, 2'b11);
        repeat (3) push_req(KIND_TICK, SEL_BOTH, 24'h5A5A5A, 1'b1, 20'hA5A5A, 2'b10);
        push_req(KIND_START, SEL_M1, 24'h7FFFFF, 1'b1, 20'hFFFFF, 2'b00);
        push_req(KIND_TICK, SEL_NONE, 24'hA5A5A5, 1'b0, 20'h5A5A5, 2'b01);
        push_req(KIND_TICK, SEL_NONE, 24'h000000, 1'b0, 20'h00000, 2'b00);
        push_req(KIND_START, SEL_BOTH, 24'hFFFFC6, 1'b0, 20'hFFFFF, 2'b00);
        repeat (7) push_req(KIND_TICK, SEL_M2, 24'h123456, 1'b0, 20'h54321, 2'b11);
        push_req(KIND_TICK, SEL_M1, 24'h000000, 1'b1, 20'h00000, 2'b11);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= spr_plan[p];
            cfg_spr = spr_plan[p];
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            while (pending_reqs.size() < PHASE_LEN) begin
                if ($urandom_range(0, 6) != 0) begin
                    queue_move(spr_plan[p]);
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        push_req(1'($urandom), 2'($urandom), 24'($urandom), 1'($urandom),
                                 20'($urandom), 2'($urandom));
                    end
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests, %0d results checked, over %0d step-per-rev settings",
                 req_count, res_count, PHASES);
        $display("Moves finished: %0d, fault stops: %0d, rejected starts: %0d",
                 n_done, n_fault, n_reject);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
